>>> hdl/wfsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow controller package
// Types, register indexes, reset values and shared arithmetic helpers of the
// wall-following steering and speed controller.
// ----------------------------------------------------------------------------
package wfsc_pkg;

  localparam int DistWidth     = 10;
  localparam int GainWidth     = 7;
  localparam int CfgIndexWidth = 4;

  typedef logic [DistWidth-1:0]  dist_t;
  typedef logic [GainWidth-1:0]  gain_t;
  typedef logic [21:0]           scaled_gain_t;
  typedef logic signed [7:0]     int8_t;
  typedef logic signed [6:0]     steer_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_MIN_DISTANCE   = 4'd0,
    REG_KP_STEER       = 4'd1,
    REG_KI_STEER       = 4'd2,
    REG_INTEGRAL_LIMIT = 4'd3,
    REG_KD_STEER       = 4'd4,
    REG_KD_DECAY       = 4'd5,
    REG_KP_SPEED       = 4'd6,
    REG_MIN_DRIVE      = 4'd7
  } cfg_reg_t;

  localparam gain_t RESET_MIN_DISTANCE   = 7'd30;
  localparam gain_t RESET_KP_STEER       = 7'd100;
  localparam gain_t RESET_KI_STEER       = 7'd0;
  localparam gain_t RESET_INTEGRAL_LIMIT = 7'd100;
  localparam gain_t RESET_KD_STEER       = 7'd0;
  localparam gain_t RESET_KD_DECAY       = 7'd0;
  localparam gain_t RESET_KP_SPEED       = 7'd50;
  localparam gain_t RESET_MIN_DRIVE      = 7'd18;

  // A product n * k below 2**14 divided by 100 equals (n * k * 20972) >> 21.
  localparam logic [14:0] DIV100_MULT  = 15'd20972;
  localparam int          DIV100_SHIFT = 21;

  localparam dist_t  FRONT_KNEE    = 10'd800;
  localparam steer_t REVERSE_STEER = 7'sd10;

  function automatic scaled_gain_t scale_gain(input gain_t k);
    return scaled_gain_t'(k) * scaled_gain_t'(DIV100_MULT);
  endfunction

  function automatic int8_t sat8(input logic signed [9:0] v);
    int8_t r;
    if (v > 10'sd127) begin
      r = 8'sd127;
    end else if (v < -10'sd128) begin
      r = -8'sd128;
    end else begin
      r = int8_t'(v);
    end
    return r;
  endfunction

  // Saturated x * k / 100 with truncation toward zero; x lies in -128..128.
  function automatic int8_t gain_term(input logic signed [8:0] x, input scaled_gain_t g);
    logic [7:0]         mag;
    logic [29:0]        prod;
    logic [8:0]         q;
    logic signed [9:0]  v;
    mag  = x[8] ? 8'(-x) : x[7:0];
    prod = 30'(mag) * 30'(g);
    q    = 9'(prod >> DIV100_SHIFT);
    v    = x[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return sat8(v);
  endfunction

endpackage

>>> hdl/wfsc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance input channel
// Valid/ready channel carrying the three measured distances.
// ----------------------------------------------------------------------------
interface wfsc_in_if
  import wfsc_pkg::*;
;
  logic  valid;
  logic  ready;
  dist_t front_distance;
  dist_t left_distance;
  dist_t right_distance;

  modport source (output valid, front_distance, left_distance, right_distance,
                  input ready);
  modport sink (input valid, front_distance, left_distance, right_distance,
                output ready);
endinterface

>>> hdl/wfsc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command output channel
// Valid/ready channel carrying the speed and steering commands.
// ----------------------------------------------------------------------------
interface wfsc_out_if
  import wfsc_pkg::*;
;
  logic   valid;
  logic   ready;
  int8_t  speed_command;
  steer_t steer_command;

  modport source (output valid, speed_command, steer_command, input ready);
  modport sink (input valid, speed_command, steer_command, output ready);
endinterface

>>> hdl/wfsc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface wfsc_cfg_if
  import wfsc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  gain_t                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/wall_follow_steer_speed_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-following steering and speed controller
// Turns front, left and right distances into a speed and a steering command.
//
// The sensor channel takes one set of distances per transfer; the command
// channel returns one speed and steering pair per item, in order. The cfg
// channel writes the eight gain and limit registers and is always ready;
// indexes above seven are ignored. Registers should only be written while
// no item is in flight.
// An item passes an input register and a result register; its command is
// valid once the result register is loaded. One item is accepted per cycle
// while the command channel does not stall.
// The controller state is updated in the same cycle the result register is
// loaded, so consecutive items see each other's state without bubbles.
// When the receiver stalls, the result holds and the input register still
// takes one more item; the sensor channel then stalls as well.
// Reset clears the controller state and loads the register defaults.
// ----------------------------------------------------------------------------
module wall_follow_steer_speed_controller
  import wfsc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  wfsc_in_if.sink    sensor,
  wfsc_out_if.source command,
  wfsc_cfg_if.sink   cfg
);

  gain_t        min_distance;
  gain_t        integral_limit;
  gain_t        min_drive;
  scaled_gain_t kp_steer;
  scaled_gain_t ki_steer;
  scaled_gain_t kd_steer;
  scaled_gain_t kd_decay;
  scaled_gain_t kp_speed;

  logic  in_valid;
  dist_t in_front;
  dist_t in_left;
  dist_t in_right;

  logic   out_valid;
  int8_t  out_speed;
  steer_t out_steer;

  logic  last_reverse;
  int8_t integral_value;
  int8_t previous_error;
  int8_t decay_value;

  logic   advance;
  logic   reverse;
  logic   last_reverse_next;
  int8_t  speed_next;
  steer_t steer_next;
  int8_t  decay_value_next;

  logic signed [10:0] diff;
  logic signed [10:0] diff_adj;
  int8_t              err;
  logic signed [8:0]  acc;
  logic signed [8:0]  acc_clamped;
  logic signed [8:0]  lim;
  logic signed [8:0]  err_delta;
  logic signed [8:0]  err_delta_adj;
  int8_t              p_term;
  int8_t              i_term;
  int8_t              d_term;
  int8_t              dec_term;
  logic signed [9:0]  steer_sum;
  int8_t              steer_sat;
  int8_t              steer_adj;
  dist_t              front_excess;
  int8_t              speed_term;
  int8_t              speed_fwd;
  logic               near;

  assign cfg.ready      = 1'b1;
  assign advance        = !out_valid || command.ready;
  assign sensor.ready   = !in_valid || advance;
  assign command.valid  = out_valid;
  assign command.speed_command = out_speed;
  assign command.steer_command = out_steer;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance   <= RESET_MIN_DISTANCE;
      integral_limit <= RESET_INTEGRAL_LIMIT;
      min_drive      <= RESET_MIN_DRIVE;
      kp_steer       <= scale_gain(RESET_KP_STEER);
      ki_steer       <= scale_gain(RESET_KI_STEER);
      kd_steer       <= scale_gain(RESET_KD_STEER);
      kd_decay       <= scale_gain(RESET_KD_DECAY);
      kp_speed       <= scale_gain(RESET_KP_SPEED);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MIN_DISTANCE:   min_distance   <= cfg.data;
        REG_KP_STEER:       kp_steer       <= scale_gain(cfg.data);
        REG_KI_STEER:       ki_steer       <= scale_gain(cfg.data);
        REG_INTEGRAL_LIMIT: integral_limit <= cfg.data;
        REG_KD_STEER:       kd_steer       <= scale_gain(cfg.data);
        REG_KD_DECAY:       kd_decay       <= scale_gain(cfg.data);
        REG_KP_SPEED:       kp_speed       <= scale_gain(cfg.data);
        REG_MIN_DRIVE:      min_drive      <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    near = (in_front < dist_t'(min_distance)) || (in_left < dist_t'(min_distance)) ||
           (in_right < dist_t'(min_distance));
    reverse = (in_front == '0) || (in_left == '0) || (in_right == '0) ||
              (near && last_reverse);

    diff     = $signed({1'b0, in_right}) - $signed({1'b0, in_left});
    diff_adj = diff[10] ? diff + 11'sd7 : diff;
    err      = int8_t'(diff_adj >>> 3);

    p_term = gain_term({err[7], err}, kp_steer);

    acc = $signed({err[7], err}) + $signed({integral_value[7], integral_value});
    lim = $signed({2'b00, integral_limit});
    if (acc > lim) begin
      acc_clamped = lim;
    end else if (acc < -lim) begin
      acc_clamped = -lim;
    end else begin
      acc_clamped = acc;
    end
    i_term = gain_term(acc_clamped, ki_steer);

    err_delta     = $signed({err[7], err}) - $signed({previous_error[7], previous_error});
    err_delta_adj = err_delta[8] ? err_delta + 9'sd1 : err_delta;
    d_term        = gain_term(err_delta_adj >>> 1, kd_steer);

    dec_term = gain_term({decay_value[7], decay_value}, kd_decay);

    steer_sum = $signed({{2{p_term[7]}}, p_term}) + $signed({{2{i_term[7]}}, i_term}) +
                $signed({{2{d_term[7]}}, d_term}) + $signed({{2{dec_term[7]}}, dec_term});
    steer_sat = sat8(steer_sum);
    steer_adj = steer_sat[7] ? steer_sat + 8'sd1 : steer_sat;

    decay_value_next = sat8($signed({{2{dec_term[7]}}, dec_term}) +
                            $signed({{2{err[7]}}, err}));

    front_excess = in_front - FRONT_KNEE;
    speed_term   = gain_term($signed({2'b00, front_excess[9:3]}), kp_speed);
    if (in_front < FRONT_KNEE) begin
      speed_fwd = $signed({1'b0, min_drive});
    end else begin
      speed_fwd = sat8($signed({{2{speed_term[7]}}, speed_term}) +
                       $signed({3'b000, min_drive}));
    end

    if (reverse) begin
      speed_next = -$signed({1'b0, min_drive});
      steer_next = (in_left < in_right) ? -REVERSE_STEER : REVERSE_STEER;
    end else begin
      speed_next = speed_fwd;
      steer_next = steer_t'(steer_adj >>> 1);
    end
    last_reverse_next = speed_next[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sensor.ready) begin
      in_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.ready) begin
      in_front <= sensor.front_distance;
      in_left  <= sensor.left_distance;
      in_right <= sensor.right_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      last_reverse   <= 1'b0;
      integral_value <= '0;
      previous_error <= '0;
      decay_value    <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        last_reverse <= last_reverse_next;
        if (!reverse) begin
          integral_value <= i_term;
          previous_error <= err;
          decay_value    <= decay_value_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_speed <= speed_next;
      out_steer <= steer_next;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !command.ready |-> !sensor.ready)
    else $error("sensor channel ready while both stages are full");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance |=> command.valid)
    else $error("item in the input register did not reach the result register");

  a_reverse_steer: assert property (@(posedge clk) disable iff (rst)
    command.valid && command.speed_command[7] |->
      (command.steer_command == REVERSE_STEER) || (command.steer_command == -REVERSE_STEER))
    else $error("reverse command without fixed steering");

  a_reverse_keeps_state: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && reverse |=>
      $stable(integral_value) && $stable(previous_error) && $stable(decay_value))
    else $error("steering state changed on a reverse step");

endmodule
